>>> hw/rtl/run_length_byte_encoder_assert.svh
// Assertion macros for the run-length byte encoder checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rlbe_pkg.sv
package rlbe_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIT_MAX = 128;
  localparam int unsigned RUN_MAX = 130;
  localparam int unsigned LIT_AW  = $clog2(LIT_MAX);
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned LANES   = 4;

  localparam logic [BYTE_W-1:0] RUN_HDR_FLAG = 8'h80;

  // Datapath operations issued by the controller
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_EXTEND   = 4'd1;
  localparam op_t OP_START    = 4'd2;
  localparam op_t OP_ADD_LIT  = 4'd3;
  localparam op_t OP_RUN_HDR  = 4'd4;
  localparam op_t OP_RUN_VAL  = 4'd5;
  localparam op_t OP_LIT_HDR  = 4'd6;
  localparam op_t OP_LIT_DATA = 4'd7;
  localparam op_t OP_FLUSH    = 4'd8;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic dec_pending;
    logic run_active;
    logic run_extend;
    logic run_match;
    logic lit_nonzero;
    logic lit_full_next;
    logic lit_last;
    logic pk_nonempty;
    logic last_item;
    logic emit_ok;
  } sts_t;

endpackage

>>> hw/rtl/rlbe_if.sv
interface rlbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface rlbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] out_count;
  logic       out_last;

  modport source(output valid, output out_byte0, output out_byte1, output out_byte2,
                 output out_byte3, output out_count, output out_last, input ready);
  modport sink(input valid, input out_byte0, input out_byte1, input out_byte2,
               input out_byte3, input out_count, input out_last, output ready);
endinterface

>>> hw/rtl/rlbe_dp.sv
module rlbe_dp import rlbe_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [BYTE_W-1:0]             in_byte,
  input  logic                          in_last,
  input  logic                          out_ready,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  output logic                          out_valid,
  output logic [LANES-1:0][BYTE_W-1:0]  out_bytes,
  output logic [2:0]                    out_count,
  output logic                          out_last
);

  // lookahead and decision window
  logic [BYTE_W-1:0] la_r [2];
  logic [1:0]        fill_r;
  logic [BYTE_W-1:0] win_r [3];
  logic [1:0]        n_r;
  logic              last_r;
  logic [1:0]        k_r;

  // run and literal group state
  logic [BYTE_W-1:0] run_val_r;
  logic [CNT_W-1:0]  run_cnt_r;
  logic [CNT_W-1:0]  lit_cnt_r;
  logic [BYTE_W-1:0] lit_mem [LIT_MAX];
  logic [BYTE_W-1:0] rd_r;
  logic [LIT_AW-1:0] rd_idx_r;

  // byte packer and output register
  logic [BYTE_W-1:0]             pk_r [LANES];
  logic [2:0]                    pk_cnt_r;
  logic                          out_valid_r;
  logic [LANES-1:0][BYTE_W-1:0]  out_bytes_r;
  logic [2:0]                    out_count_r;
  logic                          out_last_r;

  logic [BYTE_W-1:0] cur_b;
  logic [1:0]        ndec;
  logic              emit_ok;
  logic              push;
  logic [BYTE_W-1:0] push_b;
  logic [CNT_W-1:0]  run_cnt_m3;
  logic [CNT_W-1:0]  lit_cnt_m1;
  logic [LIT_AW-1:0] rd_addr;

  always_comb begin
    case (k_r)
      2'd0:    cur_b = win_r[0];
      2'd1:    cur_b = win_r[1];
      default: cur_b = win_r[2];
    endcase
  end

  assign ndec       = last_r ? n_r : ((n_r == 2'd3) ? 2'd1 : 2'd0);
  assign emit_ok    = !out_valid_r || out_ready;
  assign run_cnt_m3 = run_cnt_r - CNT_W'(3);
  assign lit_cnt_m1 = lit_cnt_r - CNT_W'(1);
  assign rd_addr    = (cmd.op == OP_LIT_HDR) ? '0 : rd_idx_r + LIT_AW'(1);

  always_comb begin
    push   = 1'b1;
    push_b = rd_r;
    case (cmd.op)
      OP_RUN_HDR:  push_b = RUN_HDR_FLAG | {1'b0, run_cnt_m3[BYTE_W-2:0]};
      OP_RUN_VAL:  push_b = run_val_r;
      OP_LIT_HDR:  push_b = lit_cnt_m1;
      OP_LIT_DATA: push_b = rd_r;
      default:     push   = 1'b0;
    endcase
  end

  always_comb begin
    sts.fill_full     = (fill_r == 2'd2);
    sts.dec_pending   = (k_r < ndec);
    sts.run_active    = (run_cnt_r != '0);
    sts.run_extend    = (cur_b == run_val_r) && (run_cnt_r < CNT_W'(RUN_MAX));
    sts.run_match     = (k_r == 2'd0) && (n_r == 2'd3) &&
                        (win_r[0] == win_r[1]) && (win_r[0] == win_r[2]);
    sts.lit_nonzero   = (lit_cnt_r != '0);
    sts.lit_full_next = (lit_cnt_r == CNT_W'(LIT_MAX - 1));
    sts.lit_last      = ({1'b0, rd_idx_r} + CNT_W'(1)) == lit_cnt_r;
    sts.pk_nonempty   = (pk_cnt_r != '0);
    sts.last_item     = last_r;
    sts.emit_ok       = emit_ok;
  end

  // literal memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ADD_LIT) begin
      lit_mem[lit_cnt_r[LIT_AW-1:0]] <= cur_b;
    end
    if (cmd.op == OP_LIT_HDR || cmd.op == OP_LIT_DATA) begin
      rd_r <= lit_mem[rd_addr];
    end
  end

  // window and lookahead payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_r[0] <= (fill_r != 2'd0) ? la_r[0] : in_byte;
      win_r[1] <= (fill_r == 2'd2) ? la_r[1] : in_byte;
      win_r[2] <= in_byte;
      if (!in_last) begin
        if (fill_r == 2'd2) begin
          la_r[0] <= la_r[1];
          la_r[1] <= in_byte;
        end else if (fill_r == 2'd1) begin
          la_r[1] <= in_byte;
        end else begin
          la_r[0] <= in_byte;
        end
      end
    end
    if (cmd.op == OP_START) begin
      run_val_r <= cur_b;
    end
    if (cmd.op == OP_LIT_HDR) begin
      rd_idx_r <= '0;
    end else if (cmd.op == OP_LIT_DATA) begin
      rd_idx_r <= rd_idx_r + LIT_AW'(1);
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      n_r       <= '0;
      last_r    <= 1'b0;
      k_r       <= '0;
      run_cnt_r <= '0;
      lit_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        n_r    <= fill_r + 2'd1;
        last_r <= in_last;
        k_r    <= '0;
        if (in_last) begin
          fill_r <= '0;
        end else if (fill_r != 2'd2) begin
          fill_r <= fill_r + 2'd1;
        end
      end
      case (cmd.op)
        OP_EXTEND: begin
          run_cnt_r <= run_cnt_r + CNT_W'(1);
          k_r       <= k_r + 2'd1;
        end
        OP_START: begin
          run_cnt_r <= CNT_W'(1);
          k_r       <= k_r + 2'd1;
        end
        OP_ADD_LIT: begin
          lit_cnt_r <= lit_cnt_r + CNT_W'(1);
          k_r       <= k_r + 2'd1;
        end
        OP_RUN_VAL: begin
          run_cnt_r <= '0;
        end
        OP_LIT_DATA: begin
          if (sts.lit_last) begin
            lit_cnt_r <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // packer payload
  always_ff @(posedge clk) begin
    if (push) begin
      if (pk_cnt_r == 3'd4) begin
        pk_r[0] <= push_b;
      end else begin
        pk_r[pk_cnt_r[1:0]] <= push_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_cnt_r <= '0;
    end else if (push) begin
      pk_cnt_r <= (pk_cnt_r == 3'd4) ? 3'd1 : pk_cnt_r + 3'd1;
    end else if (cmd.op == OP_FLUSH) begin
      pk_cnt_r <= '0;
    end
  end

  // output register: ship a full packer on the next push, a partial one on flush
  always_ff @(posedge clk) begin
    if ((push && pk_cnt_r == 3'd4) || cmd.op == OP_FLUSH) begin
      for (int i = 0; i < LANES; i++) begin
        out_bytes_r[i] <= (3'(i) < pk_cnt_r) ? pk_r[i] : '0;
      end
      out_count_r <= pk_cnt_r;
      out_last_r  <= (cmd.op == OP_FLUSH) && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((push && pk_cnt_r == 3'd4) || cmd.op == OP_FLUSH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bytes = out_bytes_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

endmodule

>>> hw/rtl/rlbe_ctrl.sv
module rlbe_ctrl import rlbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_RUN_HDR  = 3'd2;
  localparam logic [2:0] S_RUN_VAL  = 3'd3;
  localparam logic [2:0] S_LIT_HDR  = 3'd4;
  localparam logic [2:0] S_LIT_DATA = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       step_done;

  // a decision that emits nothing ends a non-final item with an empty packer
  assign step_done = !sts.last_item && !sts.pk_nonempty;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last || sts.fill_full) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (sts.dec_pending) begin
          if (sts.run_active && sts.run_extend) begin
            cmd.op = OP_EXTEND;
            if (step_done) begin
              state_nxt = S_IDLE;
            end
          end else if (sts.run_active) begin
            state_nxt = S_RUN_HDR;
          end else if (sts.run_match) begin
            if (sts.lit_nonzero) begin
              state_nxt = S_LIT_HDR;
            end else begin
              cmd.op = OP_START;
              if (step_done) begin
                state_nxt = S_IDLE;
              end
            end
          end else begin
            cmd.op = OP_ADD_LIT;
            if (sts.lit_full_next) begin
              state_nxt = S_LIT_HDR;
            end else if (step_done) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (sts.last_item && sts.run_active) begin
          state_nxt = S_RUN_HDR;
        end else if (sts.last_item && sts.lit_nonzero) begin
          state_nxt = S_LIT_HDR;
        end else if (!sts.pk_nonempty) begin
          state_nxt = S_IDLE;
        end else if (sts.emit_ok) begin
          cmd.op    = OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      S_RUN_HDR: begin
        if (sts.emit_ok) begin
          cmd.op    = OP_RUN_HDR;
          state_nxt = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        if (sts.emit_ok) begin
          cmd.op    = OP_RUN_VAL;
          state_nxt = S_DECIDE;
        end
      end
      S_LIT_HDR: begin
        if (sts.emit_ok) begin
          cmd.op    = OP_LIT_HDR;
          state_nxt = S_LIT_DATA;
        end
      end
      S_LIT_DATA: begin
        if (sts.emit_ok) begin
          cmd.op = OP_LIT_DATA;
          if (sts.lit_last) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/run_length_byte_encoder.sv
// Channel  Direction  Payload                                   Handshake
// in_ch    sink       in_byte[7:0], in_last                     valid/ready
// out_ch   source     out_byte0..3[7:0], out_count[2:0],        valid/ready
//                     out_last
//
// Steps: each item is accepted while the lookahead fills, then accepted and decided; each
//   encoded byte released is its own step, a byte is decided again after a run or group
//   closes before it, a packer with bytes is flushed; an end item decides its window.
// Reset: synchronous, active low; no clearing pass, only current-group bytes are read.
// Stalls: a result waits in the output register; the encoder holds on any byte it would
//   pack or flush while that register is occupied and not taken, and the input waits.
module run_length_byte_encoder import rlbe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  rlbe_in_if.sink    in_ch,
  rlbe_out_if.source out_ch
);

  // command and status between the sequencer and the datapath
  cmd_t cmd;
  sts_t sts;

  logic [LANES-1:0][BYTE_W-1:0] out_bytes;

  // sequencer: owns the input handshake and steps each item through its decisions
  rlbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.in_last),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // datapath: lookahead window, run and literal state, packer and output register
  rlbe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_bytes (out_bytes),
    .out_count (out_ch.out_count),
    .out_last  (out_ch.out_last)
  );

  // spread the packed lanes over the result fields, first byte in lane zero
  assign out_ch.out_byte0 = out_bytes[0];
  assign out_ch.out_byte1 = out_bytes[1];
  assign out_ch.out_byte2 = out_bytes[2];
  assign out_ch.out_byte3 = out_bytes[3];

endmodule

>>> hw/rtl/rlbe_chk.sv
`include "run_length_byte_encoder_assert.svh"

module rlbe_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte0,
  input logic [7:0] out_byte1,
  input logic [7:0] out_byte2,
  input logic [7:0] out_byte3,
  input logic [2:0] out_count,
  input logic       out_last
);

  // hold a stalled result unchanged
  `RLBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte0) && $stable(out_byte1) && $stable(out_byte2) && $stable(out_byte3) && $stable(out_count) && $stable(out_last), "stalled result changed")

  // count within one to four
  `RLBE_ASSERT_SAME(a_out_count, out_valid, out_count != 3'd0 && out_count != 3'd5 && out_count != 3'd6 && out_count != 3'd7, "result count out of range")

  // zero the unused byte slots
  `RLBE_ASSERT_SAME(a_out_pad, out_valid, (out_count > 3'd1 || out_byte1 == 8'd0) && (out_count > 3'd2 || out_byte2 == 8'd0) && (out_count > 3'd3 || out_byte3 == 8'd0), "unused byte slot not zero")

  // drop ready after the final item of a stream while it is encoded
  `RLBE_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last, !in_ready, "input taken while closing a stream")

endmodule

bind run_length_byte_encoder rlbe_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte0 (out_ch.out_byte0),
  .out_byte1 (out_ch.out_byte1),
  .out_byte2 (out_ch.out_byte2),
  .out_byte3 (out_ch.out_byte3),
  .out_count (out_ch.out_count),
  .out_last  (out_ch.out_last)
);

>>> sim/rlbe_encode_checker.sv
module rlbe_encode_checker import rlbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rlbe_in_if          in_mon,
  rlbe_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            last;
    logic [2:0]      count;
    logic [3:0][7:0] lanes;
  } enc_word_t;

  logic [7:0]  lit_mem [LIT_MAX];
  int unsigned lit_len;
  logic [7:0]  run_byte;
  int unsigned run_len;
  logic [7:0]  ahead [2];
  int unsigned ahead_fill;

  logic [7:0]  emitted [$];
  enc_word_t   words_q [$];

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  function automatic void clear_state();
    lit_len    = 0;
    run_byte   = '0;
    run_len    = 0;
    ahead[0]   = '0;
    ahead[1]   = '0;
    ahead_fill = 0;
  endfunction

  function automatic void close_group();
    if (lit_len == 0) return;
    emitted.push_back(8'(lit_len - 1));
    for (int k = 0; k < lit_len; k++) emitted.push_back(lit_mem[k]);
    lit_len = 0;
  endfunction

  function automatic void close_run();
    if (run_len == 0) return;
    emitted.push_back(RUN_HDR_FLAG | 8'((run_len - 3) & 'h7F));
    emitted.push_back(run_byte);
    run_len = 0;
  endfunction

  // Decide one byte: extend the open run, open a new run, or add a literal.
  function automatic void settle(logic [7:0] b, bit opens_run);
    if (run_len > 0) begin
      if (b == run_byte && run_len < RUN_MAX) begin
        run_len++;
        return;
      end
      close_run();
    end
    if (opens_run) begin
      close_group();
      run_byte = b;
      run_len  = 1;
      return;
    end
    lit_mem[lit_len % LIT_MAX] = b;
    lit_len++;
    if (lit_len >= LIT_MAX) close_group();
  endfunction

  function automatic void encode_item(logic [7:0] b, logic lst);
    logic [7:0]  win [3];
    int unsigned n;
    int unsigned nres;
    int unsigned cnt;
    enc_word_t   w;
    emitted.delete();
    for (int k = 0; k < ahead_fill; k++) win[k] = ahead[k];
    win[ahead_fill] = b;
    n = ahead_fill + 1;
    if (!lst) begin
      if (n == 3) begin
        settle(win[0], win[0] == win[1] && win[0] == win[2]);
        ahead[0]   = win[1];
        ahead[1]   = win[2];
        ahead_fill = 2;
      end else begin
        for (int k = 0; k < n; k++) ahead[k] = win[k];
        ahead_fill = n;
      end
    end else begin
      // nothing past the end of the stream can match
      for (int k = 0; k < n; k++)
        settle(win[k], (k + 2 < n) && win[k] == win[k + 1] && win[k] == win[k + 2]);
      close_run();
      close_group();
      clear_state();
    end
    nres = (emitted.size() + 3) / 4;
    for (int r = 0; r < nres; r++) begin
      w   = '0;
      cnt = emitted.size() - r * LANES;
      if (cnt > LANES) cnt = LANES;
      for (int k = 0; k < cnt; k++) w.lanes[k] = emitted[r * LANES + k];
      w.count = 3'(cnt);
      w.last  = lst && (r == nres - 1);
      words_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    enc_word_t got;
    enc_word_t want;
    if (!rst_n) begin
      clear_state();
      words_q.delete();
    end else begin
      // take the result first, so an item accepted on this edge cannot cover it
      if (out_mon.valid && out_mon.ready) begin
        got.lanes = {out_mon.out_byte3, out_mon.out_byte2, out_mon.out_byte1,
                     out_mon.out_byte0};
        got.count = out_mon.out_count;
        got.last  = out_mon.out_last;
        if (words_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = words_q.pop_front();
          for (int k = 0; k < LANES; k++)
            if (got.lanes[k] !== want.lanes[k]) begin
              $display("%0t ns: out_byte%0d expected %02h actual %02h",
                       $time, k, want.lanes[k], got.lanes[k]);
              fail_count++;
            end
          if (got.count !== want.count) begin
            $display("%0t ns: out_count expected %0d actual %0d",
                     $time, want.count, got.count);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t ns: out_last expected %0b actual %0b",
                     $time, want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        encode_item(in_mon.in_byte, in_mon.in_last);
    end
    words_due <= words_q.size();
  end

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Shapes of stream segment; long ones are kept rare to hold the run short.
  typedef enum {SEG_LONG_RUN, SEG_LONG_LIT, SEG_RUN, SEG_LIT, SEG_NOISE} seg_kind_t;
  // Receiver behaviour, switched every so often.
  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk;
  logic        rst_n;
  int unsigned fails;
  int unsigned words_due;

  rlbe_in_if  in_if();
  rlbe_out_if out_if();

  run_length_byte_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  rlbe_encode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fails),
    .words_due  (words_due)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  logic [7:0]  stream_q [$];
  int unsigned items_sent;
  int unsigned burst_left;
  bit          hold_armed;
  bit          hold_taken;

  // Receiver: its own stall pattern, plus one long hold-off when asked for.
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    out_if.ready = 1'b0;
    hold_taken   = 1'b0;
    mode         = RX_FREE;
    mode_left    = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 1000;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 160);
      end
      mode_left--;
      if (hold_left > 0) begin
        // hold ready low long enough for the encoder to back up to its input
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted. Between bursts, drop valid;
  // now and then a burst is long enough to count as no idling.
  task automatic offer(logic [7:0] b, logic lst);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= lst;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  // Send the queued stream, flagging its final byte as the end marker.
  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      offer(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // Drop valid and wait for every predicted result to come out.
  task automatic await_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  function automatic void push_run(logic [7:0] v, int unsigned n);
    repeat (n) stream_q.push_back(v);
  endfunction

  function automatic void push_literals(int unsigned n);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Build one stream from a handful of segments. Noise flips the low bit of a
  // base value so near-runs and accidental triples turn up often.
  function automatic void build_stream();
    seg_kind_t   kind;
    int unsigned pick;
    logic [7:0]  base;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 39);
      if (pick == 0)       kind = SEG_LONG_RUN;
      else if (pick == 1)  kind = SEG_LONG_LIT;
      else if (pick < 16)  kind = SEG_RUN;
      else if (pick < 30)  kind = SEG_LIT;
      else                 kind = SEG_NOISE;
      base = 8'($urandom_range(0, 255));
      case (kind)
        SEG_LONG_RUN: push_run(base, $urandom_range(128, 133));
        SEG_LONG_LIT: push_literals($urandom_range(126, 130));
        SEG_RUN:      push_run(base, $urandom_range(1, 8));
        SEG_LIT:      push_literals($urandom_range(1, 10));
        default:
          repeat ($urandom_range(2, 12))
            stream_q.push_back(base ^ 8'($urandom_range(0, 1)));
      endcase
    end
  endfunction

  initial begin
    int unsigned random_goal;
    int unsigned pressure_mark;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    hold_armed    = 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one-byte streams at both extremes (unused lanes must be zero)
    stream_q = '{8'h00};
    send_stream();
    stream_q = '{8'hFF};
    send_stream();
    // a pair is never a run: nothing past the end matches
    stream_q = '{8'h05, 8'h05};
    send_stream();
    // shortest run, closed by the end marker
    stream_q = '{8'h07, 8'h07, 8'h07};
    send_stream();
    // pure literal group
    stream_q = '{8'h01, 8'h02, 8'h03};
    send_stream();
    // run of four
    stream_q = '{8'h09, 8'h09, 8'h09, 8'h09};
    send_stream();
    // literals, run, literal
    stream_q = '{8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h12};
    send_stream();
    // run followed by a single literal across the sign bit
    stream_q = '{8'h80, 8'h80, 8'h80, 8'h7F};
    send_stream();
    await_drained();

    random_goal   = items_sent + 450;
    pressure_mark = items_sent + 100;
    while (items_sent < pressure_mark) begin
      build_stream();
      send_stream();
    end
    await_drained();

    // Back-pressure: the receiver holds off while a full literal group and
    // an over-long run are offered, so the output stalls the input.
    hold_armed = 1'b1;
    push_literals(130);
    push_run(8'($urandom_range(0, 255)), $urandom_range(131, 134));
    push_literals($urandom_range(1, 3));
    send_stream();
    await_drained();

    while (items_sent < random_goal) begin
      build_stream();
      send_stream();
    end
    await_drained();

    // let any stray result show up before the verdict
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rlbe_pkg.sv
hw/rtl/rlbe_if.sv
hw/rtl/rlbe_dp.sv
hw/rtl/rlbe_ctrl.sv
hw/rtl/run_length_byte_encoder.sv
hw/rtl/rlbe_chk.sv
sim/rlbe_encode_checker.sv
sim/tb.sv
